/* src/irdpl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR distance lookup package
// Widths, calibration tables, codes and shared types for the infrared
// distance piecewise linear converter.
// ----------------------------------------------------------------------------
package irdpl_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int TABLE_POINTS = 15;
  localparam int FRAC_BITS    = 8;

  localparam int IDX_W    = $clog2(TABLE_POINTS);
  localparam int CM_W     = 6;
  localparam int FIX_W    = CM_W + FRAC_BITS;
  localparam int RISE_W   = FIX_W;
  localparam int PROD_W   = RISE_W + SAMPLE_BITS;
  localparam int QUO_W    = RISE_W;
  localparam int CNT_W    = $clog2(QUO_W);
  localparam int DIST_W   = 14;
  localparam int REGION_W = 2;
  localparam int SEG_W    = 4;

  typedef logic [CM_W-1:0]        cm_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [FIX_W-1:0]       fix_t;
  typedef logic [IDX_W-1:0]       idx_t;

  localparam cm_t CAL_DIST [TABLE_POINTS] = '{
    6'd9, 6'd12, 6'd15, 6'd18, 6'd21, 6'd24, 6'd27, 6'd30,
    6'd33, 6'd36, 6'd39, 6'd42, 6'd45, 6'd48, 6'd50
  };

  localparam sample_t CAL_READ [TABLE_POINTS] = '{
    12'd3445, 12'd3185, 12'd3009, 12'd2924, 12'd2822, 12'd2763, 12'd2713,
    12'd2685, 12'd2632, 12'd2600, 12'd2571, 12'd2558, 12'd2533, 12'd2518,
    12'd2507
  };

  localparam idx_t LAST_IDX = IDX_W'(TABLE_POINTS - 1);

  typedef enum logic [REGION_W-1:0] {
    REGION_INTERP = 2'd0,
    REGION_NEAR   = 2'd1,
    REGION_FAR    = 2'd2
  } region_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_SEARCH,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
  } div_sts_t;

  function automatic fix_t to_fixed(cm_t cm);
    return FIX_W'(cm) << FRAC_BITS;
  endfunction

endpackage

/* src/irdpl_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR distance lookup divider
// Restoring shift-subtract divider, one quotient bit per cycle. The
// quotient is known to fit in QUO_W bits.
// ----------------------------------------------------------------------------
module irdpl_div (
  input  logic                              clk,
  input  logic                              rst,
  input  irdpl_pkg::div_ctl_t               ctl,
  input  logic [irdpl_pkg::PROD_W-1:0]      dividend,
  input  logic [irdpl_pkg::SAMPLE_BITS-1:0] divisor,
  output logic [irdpl_pkg::QUO_W-1:0]       quotient,
  output irdpl_pkg::div_sts_t               sts
);

  logic                              busy;
  logic [irdpl_pkg::CNT_W-1:0]       cnt;
  logic [irdpl_pkg::SAMPLE_BITS-1:0] rem;
  logic [irdpl_pkg::QUO_W-1:0]       work;
  logic [irdpl_pkg::SAMPLE_BITS:0]   trial;
  logic [irdpl_pkg::SAMPLE_BITS:0]   diff;
  logic                              ge;

  assign trial = {rem, work[irdpl_pkg::QUO_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= irdpl_pkg::CNT_W'(irdpl_pkg::QUO_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem  <= dividend[irdpl_pkg::PROD_W-1 -: irdpl_pkg::SAMPLE_BITS];
      work <= dividend[irdpl_pkg::QUO_W-1:0];
    end else if (busy) begin
      rem  <= ge ? diff[irdpl_pkg::SAMPLE_BITS-1:0] : trial[irdpl_pkg::SAMPLE_BITS-1:0];
      work <= {work[irdpl_pkg::QUO_W-2:0], ge};
    end
  end

  assign quotient = work;
  assign sts.busy = busy;

endmodule

/* src/ir_distance_piecewise_linear_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR distance piecewise linear converter
// Maps a 12-bit infrared sample to a Q6.8 distance through a 15-point
// calibration table with linear interpolation inside a segment.
// ----------------------------------------------------------------------------
// One request at a time: in_ready is high only while idle. A clamped reading
// goes from the clamp check straight to its result. An interpolated reading
// passes through a linear segment search that tests one table point per cycle,
// a multiply state, a divider load state and a 14-step shift-subtract divider
// producing one quotient bit per cycle. The result is held until out_ready.
module ir_distance_piecewise_linear_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [irdpl_pkg::SAMPLE_BITS-1:0] raw_reading,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [irdpl_pkg::DIST_W-1:0]      distance_q8,
  output logic [irdpl_pkg::REGION_W-1:0]    region,
  output logic [irdpl_pkg::SEG_W-1:0]       segment
);

  irdpl_pkg::state_t  state, state_next;
  irdpl_pkg::sample_t x;
  irdpl_pkg::idx_t    idx;
  irdpl_pkg::idx_t    idx_inc;
  irdpl_pkg::fix_t    base;
  logic [irdpl_pkg::RISE_W-1:0] rise;
  irdpl_pkg::sample_t off;
  irdpl_pkg::sample_t span;
  logic [irdpl_pkg::PROD_W-1:0] product;
  logic [irdpl_pkg::DIST_W-1:0] dist_r;
  irdpl_pkg::region_t region_r;
  logic [irdpl_pkg::SEG_W-1:0]  seg;
  logic [irdpl_pkg::QUO_W-1:0]  quo;
  logic [irdpl_pkg::FIX_W:0]    sum;
  logic                         near_hit;
  logic                         far_hit;
  logic                         seg_hit;
  logic                         last_seg;
  irdpl_pkg::div_ctl_t          div_ctl;
  irdpl_pkg::div_sts_t          div_sts;

  assign idx_inc  = idx + 1'b1;
  assign near_hit = x >= irdpl_pkg::CAL_READ[0];
  assign far_hit  = x <= irdpl_pkg::CAL_READ[irdpl_pkg::LAST_IDX];
  assign seg_hit  = (x <= irdpl_pkg::CAL_READ[idx]) && (x > irdpl_pkg::CAL_READ[idx_inc]);
  assign last_seg = idx == irdpl_pkg::LAST_IDX - 1'b1;
  assign sum      = (irdpl_pkg::FIX_W + 1)'(base) + (irdpl_pkg::FIX_W + 1)'(quo);

  irdpl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (product),
    .divisor  (span),
    .quotient (quo),
    .sts      (div_sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irdpl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      irdpl_pkg::ST_IDLE: begin
        if (in_valid) state_next = irdpl_pkg::ST_CLAMP;
      end
      irdpl_pkg::ST_CLAMP: begin
        if (near_hit || far_hit) state_next = irdpl_pkg::ST_DONE;
        else state_next = irdpl_pkg::ST_SEARCH;
      end
      irdpl_pkg::ST_SEARCH: begin
        if (seg_hit) state_next = irdpl_pkg::ST_MUL;
        else if (last_seg) state_next = irdpl_pkg::ST_DONE;
      end
      irdpl_pkg::ST_MUL:  state_next = irdpl_pkg::ST_LOAD;
      irdpl_pkg::ST_LOAD: state_next = irdpl_pkg::ST_DIV;
      irdpl_pkg::ST_DIV: begin
        if (!div_sts.busy) state_next = irdpl_pkg::ST_DONE;
      end
      irdpl_pkg::ST_DONE: begin
        if (out_ready) state_next = irdpl_pkg::ST_IDLE;
      end
      default: state_next = irdpl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = state == irdpl_pkg::ST_IDLE;
    out_valid     = state == irdpl_pkg::ST_DONE;
    div_ctl.start = state == irdpl_pkg::ST_LOAD;
  end

  always_ff @(posedge clk) begin
    case (state)
      irdpl_pkg::ST_IDLE: begin
        x   <= raw_reading;
        idx <= '0;
      end
      irdpl_pkg::ST_CLAMP: begin
        if (near_hit) begin
          dist_r   <= irdpl_pkg::DIST_W'(irdpl_pkg::to_fixed(irdpl_pkg::CAL_DIST[0]));
          region_r <= irdpl_pkg::REGION_NEAR;
          seg      <= '0;
        end else if (far_hit) begin
          dist_r   <= irdpl_pkg::DIST_W'(
                        irdpl_pkg::to_fixed(irdpl_pkg::CAL_DIST[irdpl_pkg::LAST_IDX]));
          region_r <= irdpl_pkg::REGION_FAR;
          seg      <= irdpl_pkg::SEG_W'(irdpl_pkg::LAST_IDX - 1'b1);
        end
      end
      irdpl_pkg::ST_SEARCH: begin
        if (seg_hit) begin
          seg      <= irdpl_pkg::SEG_W'(idx);
          region_r <= irdpl_pkg::REGION_INTERP;
          base     <= irdpl_pkg::to_fixed(irdpl_pkg::CAL_DIST[idx]);
          if (irdpl_pkg::CAL_DIST[idx_inc] >= irdpl_pkg::CAL_DIST[idx]) begin
            rise <= irdpl_pkg::to_fixed(irdpl_pkg::CAL_DIST[idx_inc]
                                        - irdpl_pkg::CAL_DIST[idx]);
          end else begin
            rise <= '0;
          end
          off  <= irdpl_pkg::CAL_READ[idx] - x;
          span <= irdpl_pkg::CAL_READ[idx] - irdpl_pkg::CAL_READ[idx_inc];
        end else if (last_seg) begin
          dist_r   <= irdpl_pkg::DIST_W'(
                        irdpl_pkg::to_fixed(irdpl_pkg::CAL_DIST[irdpl_pkg::LAST_IDX]));
          region_r <= irdpl_pkg::REGION_FAR;
          seg      <= irdpl_pkg::SEG_W'(irdpl_pkg::LAST_IDX - 1'b1);
        end else begin
          idx <= idx_inc;
        end
      end
      irdpl_pkg::ST_MUL: begin
        product <= irdpl_pkg::PROD_W'(rise) * irdpl_pkg::PROD_W'(off);
      end
      irdpl_pkg::ST_DIV: begin
        if (!div_sts.busy) dist_r <= irdpl_pkg::DIST_W'(sum);
      end
      default: begin
      end
    endcase
  end

  assign distance_q8 = dist_r;
  assign region      = region_r;
  assign segment     = seg;

endmodule

/* src/irdpl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR distance lookup port checker
// Watches the converter ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module irdpl_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [irdpl_pkg::SAMPLE_BITS-1:0] raw_reading,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [irdpl_pkg::DIST_W-1:0]      distance_q8,
  input logic [irdpl_pkg::REGION_W-1:0]    region,
  input logic [irdpl_pkg::SEG_W-1:0]       segment
);

  logic [irdpl_pkg::DIST_W-1:0] near_dist;
  logic [irdpl_pkg::DIST_W-1:0] far_dist;
  logic [irdpl_pkg::SEG_W-1:0]  far_seg;

  assign near_dist = irdpl_pkg::DIST_W'(irdpl_pkg::to_fixed(irdpl_pkg::CAL_DIST[0]));
  assign far_dist  = irdpl_pkg::DIST_W'(
                       irdpl_pkg::to_fixed(irdpl_pkg::CAL_DIST[irdpl_pkg::LAST_IDX]));
  assign far_seg   = irdpl_pkg::SEG_W'(irdpl_pkg::LAST_IDX - 1'b1);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance_q8)
      && $stable(region) && $stable(segment))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && raw_reading != '1 |=> !in_ready)
    else $error("ready again right after accepting a request");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("accepting while a result is pending");

  a_near_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && region == irdpl_pkg::REGION_NEAR |-> segment == '0
      && distance_q8 == near_dist)
    else $error("near clamp result mismatch");

  a_far_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && region == irdpl_pkg::REGION_FAR |-> segment == far_seg
      && distance_q8 == far_dist)
    else $error("far clamp result mismatch");

endmodule

bind ir_distance_piecewise_linear_core irdpl_checker u_irdpl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .raw_reading (raw_reading),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .distance_q8 (distance_q8),
  .region      (region),
  .segment     (segment)
);

/* verif/ir_distance_piecewise_linear_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR distance converter testbench
// Feeds raw infrared samples through the valid/ready request channel and
// checks every converted distance, region and segment against a local
// piecewise linear predictor built on the package calibration tables.
// Random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module ir_distance_piecewise_linear_core_test;
  import irdpl_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 1500;

  typedef struct packed {
    logic [DIST_W-1:0] dist_q8;
    region_t           reg_code;
    logic [SEG_W-1:0]  seg;
  } conversion_t;

  typedef struct {
    sample_t reading;
    int      gap;
  } sample_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  sample_t              raw_reading = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DIST_W-1:0]    distance_q8;
  logic [REGION_W-1:0]  region;
  logic [SEG_W-1:0]     segment;

  sample_req_t pending_reads[$];
  conversion_t expected_conv[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          stall_cnt = 0;
  bit          steady_sink = 1'b0;
  int          near_seen = 0;
  int          far_seen = 0;
  int          interp_seen = 0;

  ir_distance_piecewise_linear_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .raw_reading (raw_reading),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .distance_q8 (distance_q8),
    .region      (region),
    .segment     (segment)
  );

  always #4 clk = ~clk;

  function automatic conversion_t convert_reading(sample_t x);
    conversion_t res;
    int unsigned rise;
    int unsigned off;
    int unsigned span;
    int unsigned add;
    int unsigned base;
    res.dist_q8 = DIST_W'(int'(CAL_DIST[TABLE_POINTS-1]) << FRAC_BITS);
    res.reg_code = REGION_FAR;
    res.seg = SEG_W'(TABLE_POINTS - 2);
    if (x >= CAL_READ[0]) begin
      res.dist_q8 = DIST_W'(int'(CAL_DIST[0]) << FRAC_BITS);
      res.reg_code = REGION_NEAR;
      res.seg = '0;
    end else if (x > CAL_READ[TABLE_POINTS-1]) begin
      for (int i = 0; i < TABLE_POINTS - 1; i++) begin
        if (x <= CAL_READ[i] && x > CAL_READ[i+1]) begin
          base = int'(CAL_DIST[i]) << FRAC_BITS;
          span = int'(CAL_READ[i]) - int'(CAL_READ[i+1]);
          off  = int'(CAL_READ[i]) - int'(x);
          add  = 0;
          if (span != 0 && CAL_DIST[i+1] >= CAL_DIST[i]) begin
            rise = (int'(CAL_DIST[i+1]) - int'(CAL_DIST[i])) << FRAC_BITS;
            add  = (rise * off) / span;
          end
          res.dist_q8 = DIST_W'(base + add);
          res.reg_code = REGION_INTERP;
          res.seg = SEG_W'(i);
          break;
        end
      end
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_reading(sample_t x, int gap);
    sample_req_t req;
    req.reading = x;
    req.gap = gap;
    pending_reads.push_back(req);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_conv.push_back(convert_reading(raw_reading));
      end
      if (!in_valid || in_ready) begin
        if (pending_reads.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_reads[0].gap > 0) begin
          pending_reads[0].gap = pending_reads[0].gap - 1;
          in_valid <= 1'b0;
        end else begin
          raw_reading <= pending_reads[0].reading;
          in_valid <= 1'b1;
          void'(pending_reads.pop_front());
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    conversion_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (out_valid && out_ready) begin
        case (region)
          REGION_NEAR:   near_seen++;
          REGION_FAR:    far_seen++;
          default:       interp_seen++;
        endcase
        if (expected_conv.size() == 0) begin
          report_mismatch($sformatf(
            "result with no request pending: dist %0d region %0d seg %0d",
            distance_q8, region, segment));
        end else begin
          want = expected_conv.pop_front();
          if (distance_q8 !== want.dist_q8)
            report_mismatch($sformatf("distance_q8: got %0d, expected %0d",
                                      distance_q8, want.dist_q8));
          if (region !== want.reg_code)
            report_mismatch($sformatf("region: got %0d, expected %0d",
                                      region, want.reg_code));
          if (segment !== want.seg)
            report_mismatch($sformatf("segment: got %0d, expected %0d",
                                      segment, want.seg));
        end
        if ($urandom_range(0, 39) == 0) steady_sink = ~steady_sink;
      end
      if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready && !steady_sink) begin
        stall_cnt <= pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit      calm;
    sample_t x;
    int      roll;

    // extremes, clamp edges and every table point
    queue_reading(12'd0, 0);
    queue_reading(12'hFFF, 0);
    queue_reading(12'hAAA, 0);
    queue_reading(12'h555, 0);
    queue_reading(CAL_READ[0] + 12'd1, 0);
    queue_reading(CAL_READ[0], 0);
    queue_reading(CAL_READ[0] - 12'd1, 0);
    queue_reading(CAL_READ[TABLE_POINTS-1] + 12'd1, 0);
    queue_reading(CAL_READ[TABLE_POINTS-1], 0);
    queue_reading(CAL_READ[TABLE_POINTS-1] - 12'd1, 0);
    for (int i = 1; i < TABLE_POINTS - 1; i++) begin
      queue_reading(CAL_READ[i], $urandom_range(0, 2));
    end

    calm = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        x = sample_t'($urandom_range(CAL_READ[TABLE_POINTS-1], CAL_READ[0]));
      end else if (roll < 85) begin
        x = CAL_READ[$urandom_range(0, TABLE_POINTS - 1)] + sample_t'($urandom_range(0, 2))
            - sample_t'(1);
      end else begin
        x = sample_t'($urandom_range(0, 4095));
      end
      queue_reading(x, calm ? 0 : pick_gap());
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while ((pending_reads.size() != 0 || in_valid || expected_conv.size() != 0)
           && idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
    end
    for (int c = 0; c < DRAIN_CYCLES && idle_cycles < IDLE_LIMIT; c++) begin
      @(posedge clk);
    end

    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
    end else begin
      $display("Converted %0d near-clamped, %0d far-clamped and %0d interpolated readings,",
               near_seen, far_seen, interp_seen);
      $display("with random request gaps and result stalls; %0d mismatches.", mismatches);
      if (mismatches == 0 && expected_conv.size() == 0) begin
        $display("No mismatches found");
      end else begin
        $display("Mismatches found");
      end
    end
    $finish;
  end

endmodule
